@@ hw/rtl/lbhc_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbhc_pkg
// Shared types and constants of the hash cache with least-recently-used
// eviction under a byte budget.
// ---------------------------------------------------------------------------
package lbhc_pkg;

	// table geometry
	localparam int SLOT_BITS = 10;
	localparam int SLOTS     = 1 << SLOT_BITS;

	// field widths
	localparam int KEY_W    = 64;
	localparam int SIZE_W   = 32;
	localparam int TIME_W   = 40;
	localparam int CNT_W    = 40;
	localparam int BYTES_W  = 41;
	localparam int IDX_W    = 16;
	localparam int STAT_W   = 2;
	localparam int ENTRY_CW = SLOT_BITS + 1;

	// hash: only the low bits of the product reach the slot index
	localparam int HASH_SHIFT = 33;
	localparam int HASH_W     = SLOT_BITS + HASH_SHIFT;
	localparam int HALF_W     = (HASH_W + 1) / 2;
	localparam logic [63:0] HASH_MUL = 64'hff51afd7ed558ccd;
	localparam logic [HASH_W-1:0] HASH_MUL_LO = HASH_MUL[HASH_W-1:0];

	// result status codes
	localparam logic [STAT_W-1:0] STAT_HIT    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_INSERT = 2'd1;
	localparam logic [STAT_W-1:0] STAT_REJECT = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 2'd1;
	localparam logic [BYTES_W-1:0] BUDGET_RESET = 41'd8388608;

	// one table entry; zero key means empty
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] size;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH_LO,
		ST_HASH_HI,
		ST_PROBE_RD,
		ST_PROBE_CHK,
		ST_FIT,
		ST_SCAN,
		ST_EVICT,
		ST_CLAIM
	} state_t;

endpackage

@@ hw/rtl/lbhc_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbhc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lbhc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/lru_budget_hash_cache.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lru_budget_hash_cache
// Linear-probing hash cache of device buffers with least-recently-used
// eviction under a byte budget, run by a small sequencer over one table RAM.
// ---------------------------------------------------------------------------
//  channel   signals                                       handshake
//  request   start, busy, layer_index, weight_index,       start && !busy
//            byte_count
//  result    done, status, slot_index, evicted_now,        done, one cycle
//            counters, bytes_in_use, entries_in_use
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data     cfg_valid && cfg_ready
//
//  A rejected request answers in the next cycle. Otherwise hash states
//  (one shared multiplier over two halves), a read and a check state per
//  probe step, then on a free slot or a resized key a fit check and a claim;
//  each eviction adds a table scan through the read port, an evict state
//  and another fit check. After reset a clearing pass zeroes the table; busy is
//  high meanwhile and cfg_ready is low while busy. Results cannot be stalled.
// ---------------------------------------------------------------------------
module lru_budget_hash_cache (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [lbhc_pkg::IDX_W-1:0]      layer_index,
	input  logic [lbhc_pkg::IDX_W-1:0]      weight_index,
	input  logic [lbhc_pkg::SIZE_W-1:0]     byte_count,
	output logic                            done,
	output logic [lbhc_pkg::STAT_W-1:0]     status,
	output logic [lbhc_pkg::SLOT_BITS-1:0]  slot_index,
	output logic [lbhc_pkg::ENTRY_CW-1:0]   evicted_now,
	output logic [lbhc_pkg::CNT_W-1:0]      hit_total,
	output logic [lbhc_pkg::CNT_W-1:0]      miss_total,
	output logic [lbhc_pkg::CNT_W-1:0]      eviction_total,
	output logic [lbhc_pkg::CNT_W-1:0]      upload_total,
	output logic [lbhc_pkg::BYTES_W-1:0]    bytes_in_use,
	output logic [lbhc_pkg::ENTRY_CW-1:0]   entries_in_use,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lbhc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lbhc_pkg::BYTES_W-1:0]    cfg_data
);
	import lbhc_pkg::*;

	state_t state_q, state_d;

	// configuration
	logic               enable_q;
	logic [BYTES_W-1:0] budget_q;

	// request and progress
	logic [KEY_W-1:0]     key_q;
	logic [SIZE_W-1:0]    need_q;
	logic [HASH_W-1:0]    acc_q;
	logic [SLOT_BITS-1:0] probe_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic [SLOT_BITS-1:0] clr_q;
	logic [SLOT_BITS:0]   scan_q;
	logic                 chk_v_s1;
	logic [SLOT_BITS-1:0] chk_addr_s1;
	logic [TIME_W:0]      oldest_q;
	logic [SLOT_BITS-1:0] best_q;
	logic [SIZE_W-1:0]    best_size_q;
	logic                 any_q;
	logic [ENTRY_CW-1:0]  evicted_q;

	// statistics and occupancy
	logic [TIME_W-1:0]   clock_q;
	logic [CNT_W-1:0]    hit_q, miss_q, evict_q, upload_q;
	logic [BYTES_W-1:0]  bytes_q;
	logic [ENTRY_CW-1:0] entries_q;

	// result word
	logic                 done_q;
	logic [STAT_W-1:0]    status_q;
	logic [SLOT_BITS-1:0] slot_out_q;
	logic [ENTRY_CW-1:0]  ev_out_q;

	// table ram
	logic                 wr_en, rd_en;
	logic [SLOT_BITS-1:0] wr_addr, rd_addr;
	entry_t               wr_data, rd_data;

	lbhc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// shared multiplier over the two halves of the mixed key
	logic [HASH_W-1:0]        mixed;
	logic [HALF_W-1:0]        mul_op;
	logic [HASH_W-1:0]        prod;
	logic [SLOT_BITS-1:0]     base;
	logic [SLOT_BITS-1:0]     probe_addr;

	assign mixed  = key_q[HASH_W-1:0] ^ HASH_W'(key_q >> HASH_SHIFT);
	assign mul_op = (state_q == ST_HASH_LO) ? mixed[HALF_W-1:0]
		: HALF_W'(mixed[HASH_W-1:HALF_W]);
	assign prod   = HASH_W'(mul_op) * HASH_MUL_LO;
	assign base   = acc_q[SLOT_BITS-1:0] ^ acc_q[HASH_W-1:HASH_SHIFT];
	assign probe_addr = base + probe_q;

	// request checks
	logic        reject;
	logic [SIZE_W-1:0] wkey_p1;
	logic        key_eq, key_zero, size_eq, over;
	logic [TIME_W-1:0] clock_next;
	logic        scan_better;

	assign wkey_p1  = SIZE_W'(weight_index) + SIZE_W'(1);
	assign reject   = !enable_q || byte_count == '0
		|| {9'd0, byte_count} > budget_q;
	assign key_eq   = rd_data.key == key_q;
	assign key_zero = rd_data.key == '0;
	assign size_eq  = rd_data.size == need_q;
	assign over     = ({1'b0, bytes_q} + 42'(need_q)) > {1'b0, budget_q};
	assign clock_next = clock_q + 1'b1;
	assign scan_better = chk_v_s1 && !key_zero && {1'b0, rd_data.stamp} < oldest_q;

	// next state and ram control
	always_comb begin
		state_d = state_q;
		wr_en   = 1'b0;
		wr_addr = slot_q;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = probe_addr;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start && !reject) begin
					state_d = ST_HASH_LO;
				end
			end
			ST_HASH_LO: state_d = ST_HASH_HI;
			ST_HASH_HI: state_d = ST_PROBE_RD;
			ST_PROBE_RD: begin
				rd_en   = 1'b1;
				state_d = ST_PROBE_CHK;
			end
			ST_PROBE_CHK: begin
				if (key_eq && size_eq) begin
					wr_en   = 1'b1;
					wr_addr = probe_addr;
					wr_data = '{key: rd_data.key, size: rd_data.size, stamp: clock_next};
					state_d = ST_IDLE;
				end else if (key_eq) begin
					// same key, other size: give the slot back first
					wr_en   = 1'b1;
					wr_addr = probe_addr;
					state_d = ST_FIT;
				end else if (key_zero) begin
					state_d = ST_FIT;
				end else if (probe_q == '1) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_PROBE_RD;
				end
			end
			ST_FIT: state_d = over ? ST_SCAN : ST_CLAIM;
			ST_SCAN: begin
				rd_en   = !scan_q[SLOT_BITS];
				rd_addr = scan_q[SLOT_BITS-1:0];
				if (scan_q[SLOT_BITS] && !chk_v_s1) begin
					state_d = ST_EVICT;
				end
			end
			ST_EVICT: begin
				if (any_q) begin
					wr_en   = 1'b1;
					wr_addr = best_q;
					state_d = ST_FIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_CLAIM: begin
				wr_en   = 1'b1;
				wr_data = '{key: key_q, size: need_q, stamp: clock_q};
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			budget_q <= BUDGET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ENABLE: enable_q <= cfg_data[0];
				CFG_BUDGET: budget_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// control, counters and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			chk_v_s1  <= 1'b0;
			clock_q   <= '0;
			hit_q     <= '0;
			miss_q    <= '0;
			evict_q   <= '0;
			upload_q  <= '0;
			bytes_q   <= '0;
			entries_q <= '0;
			done_q    <= 1'b0;
			any_q     <= 1'b0;
			scan_q    <= '0;
			probe_q   <= '0;
			evicted_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					if (start) begin
						key_q     <= {IDX_W'(0), layer_index, wkey_p1};
						need_q    <= byte_count;
						probe_q   <= '0;
						evicted_q <= '0;
						if (reject) begin
							done_q     <= 1'b1;
							status_q   <= STAT_REJECT;
							slot_out_q <= '0;
							ev_out_q   <= '0;
						end
					end
				end
				ST_HASH_LO: acc_q <= prod;
				ST_HASH_HI: acc_q <= acc_q + (prod << HALF_W);
				ST_PROBE_RD: ;
				ST_PROBE_CHK: begin
					slot_q  <= probe_addr;
					probe_q <= probe_q + 1'b1;
					if (key_eq || key_zero || probe_q == '1) begin
						clock_q <= clock_next;
					end
					if (key_eq && size_eq) begin
						hit_q      <= hit_q + 1'b1;
						done_q     <= 1'b1;
						status_q   <= STAT_HIT;
						slot_out_q <= probe_addr;
						ev_out_q   <= '0;
					end else if (key_eq) begin
						miss_q  <= miss_q + 1'b1;
						bytes_q <= bytes_q - BYTES_W'(rd_data.size);
						if (entries_q != '0) begin
							entries_q <= entries_q - 1'b1;
						end
					end else if (key_zero) begin
						miss_q <= miss_q + 1'b1;
					end else if (probe_q == '1) begin
						miss_q     <= miss_q + 1'b1;
						done_q     <= 1'b1;
						status_q   <= STAT_FULL;
						slot_out_q <= '0;
						ev_out_q   <= '0;
					end
				end
				ST_FIT: begin
					scan_q   <= '0;
					chk_v_s1 <= 1'b0;
					oldest_q <= '1;
					any_q    <= 1'b0;
				end
				ST_SCAN: begin
					// issue one read a cycle, check the previous one
					chk_v_s1    <= !scan_q[SLOT_BITS];
					chk_addr_s1 <= scan_q[SLOT_BITS-1:0];
					if (!scan_q[SLOT_BITS]) begin
						scan_q <= scan_q + 1'b1;
					end
					if (scan_better) begin
						oldest_q    <= {1'b0, rd_data.stamp};
						best_q      <= chk_addr_s1;
						best_size_q <= rd_data.size;
						any_q       <= 1'b1;
					end
				end
				ST_EVICT: begin
					if (any_q) begin
						bytes_q   <= bytes_q - BYTES_W'(best_size_q);
						if (entries_q != '0) begin
							entries_q <= entries_q - 1'b1;
						end
						evict_q   <= evict_q + 1'b1;
						evicted_q <= evicted_q + 1'b1;
					end else begin
						done_q     <= 1'b1;
						status_q   <= STAT_REJECT;
						slot_out_q <= '0;
						ev_out_q   <= evicted_q;
					end
				end
				ST_CLAIM: begin
					entries_q  <= entries_q + 1'b1;
					bytes_q    <= bytes_q + BYTES_W'(need_q);
					upload_q   <= upload_q + 1'b1;
					done_q     <= 1'b1;
					status_q   <= STAT_INSERT;
					slot_out_q <= slot_q;
					ev_out_q   <= evicted_q;
				end
				default: ;
			endcase
		end
	end

	// ports
	assign busy           = state_q != ST_IDLE;
	assign cfg_ready      = !busy;
	assign done           = done_q;
	assign status         = status_q;
	assign slot_index     = slot_out_q;
	assign evicted_now    = ev_out_q;
	assign hit_total      = hit_q;
	assign miss_total     = miss_q;
	assign eviction_total = evict_q;
	assign upload_total   = upload_q;
	assign bytes_in_use   = bytes_q;
	assign entries_in_use = entries_q;

endmodule

@@ tb/sv/lru_budget_hash_cache_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lru_budget_hash_cache_tb
// Drives lookup requests into the hash cache and checks every result word
// against a cycle-free model of the table, its eviction order and counters.
// ---------------------------------------------------------------------------
module lru_budget_hash_cache_tb;
	import lbhc_pkg::*;

	localparam int CYCLE_LIMIT = 6000000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct {
		logic [IDX_W-1:0]  layer;
		logic [IDX_W-1:0]  weight;
		logic [SIZE_W-1:0] bytes;
		bit                drain;
	} request_t;

	typedef struct {
		logic [STAT_W-1:0]    stat;
		logic [SLOT_BITS-1:0] slot;
		logic [ENTRY_CW-1:0]  evicted;
		logic [CNT_W-1:0]     hits;
		logic [CNT_W-1:0]     misses;
		logic [CNT_W-1:0]     evictions;
		logic [CNT_W-1:0]     uploads;
		logic [BYTES_W-1:0]   bytes;
		logic [ENTRY_CW-1:0]  entries;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [IDX_W-1:0] layer_index = '0;
	logic [IDX_W-1:0] weight_index = '0;
	logic [SIZE_W-1:0] byte_count = '0;
	logic done;
	logic [STAT_W-1:0] status;
	logic [SLOT_BITS-1:0] slot_index;
	logic [ENTRY_CW-1:0] evicted_now;
	logic [CNT_W-1:0] hit_total, miss_total, eviction_total, upload_total;
	logic [BYTES_W-1:0] bytes_in_use;
	logic [ENTRY_CW-1:0] entries_in_use;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTES_W-1:0] cfg_data = '0;

	lru_budget_hash_cache i_dut (.*);

	always #5 clk = ~clk;

	// model of the table
	logic [KEY_W-1:0]    tbl_key [SLOTS];
	logic [SIZE_W-1:0]   tbl_size [SLOTS];
	logic [TIME_W-1:0]   tbl_used [SLOTS];
	logic [TIME_W-1:0]   now_tick;
	logic [BYTES_W-1:0]  held_bytes;
	logic [ENTRY_CW-1:0] held_entries;
	logic [CNT_W-1:0]    n_hit, n_miss, n_evict, n_upload;
	logic                en_reg;
	logic [BYTES_W-1:0]  budget_reg;

	request_t pending[$];
	answer_t  awaited[$];
	request_t cur;
	int       send_idle_pct = 0;
	int       errors = 0;
	int       cycles = 0;

	function automatic logic [SLOT_BITS-1:0] home_slot(logic [KEY_W-1:0] k);
		k = k ^ (k >> HASH_SHIFT);
		k = k * HASH_MUL;
		k = k ^ (k >> HASH_SHIFT);
		return k[SLOT_BITS-1:0];
	endfunction

	task automatic drop_slot(int s);
		held_bytes = held_bytes - BYTES_W'(tbl_size[s]);
		tbl_key[s] = '0;
		tbl_size[s] = '0;
		tbl_used[s] = '0;
		if (held_entries > 0) held_entries = held_entries - 1'b1;
	endtask

	function automatic answer_t pack_answer(logic [STAT_W-1:0] st, int sl, int ev);
		answer_t a;
		a.stat = st;
		a.slot = SLOT_BITS'(sl);
		a.evicted = ENTRY_CW'(ev);
		a.hits = n_hit;
		a.misses = n_miss;
		a.evictions = n_evict;
		a.uploads = n_upload;
		a.bytes = held_bytes;
		a.entries = held_entries;
		return a;
	endfunction

	// work out the answer of one accepted request
	task automatic serve_request(request_t r);
		logic [KEY_W-1:0] k;
		logic [SLOT_BITS-1:0] base;
		int slot, ev, s, best;
		bit have, found, any;
		logic [63:0] oldest;
		slot = 0; ev = 0; have = 0; found = 0;
		if (!en_reg || r.bytes == 0 || BYTES_W'(r.bytes) > budget_reg) begin
			awaited.push_back(pack_answer(STAT_REJECT, 0, 0));
			return;
		end
		k = {16'd0, r.layer, 32'(r.weight) + 32'd1};
		base = home_slot(k);
		for (int i = 0; i < SLOTS; i++) begin
			s = int'(SLOT_BITS'(base + i));
			if (tbl_key[s] == k) begin
				slot = s; have = 1; found = 1;
				break;
			end
			if (tbl_key[s] == 0) begin
				slot = s; have = 1;
				break;
			end
		end
		now_tick = now_tick + 1'b1;
		if (found && tbl_size[slot] == r.bytes) begin
			tbl_used[slot] = now_tick;
			n_hit = n_hit + 1'b1;
			awaited.push_back(pack_answer(STAT_HIT, slot, 0));
			return;
		end
		n_miss = n_miss + 1'b1;
		if (!have) begin
			awaited.push_back(pack_answer(STAT_FULL, 0, 0));
			return;
		end
		if (found) drop_slot(slot);
		// evict oldest entries until the request fits
		while ({1'b0, held_bytes} + 42'(r.bytes) > {1'b0, budget_reg}) begin
			oldest = '1; best = 0; any = 0;
			for (s = 0; s < SLOTS; s++) begin
				if (tbl_key[s] != 0 && 64'(tbl_used[s]) < oldest) begin
					oldest = 64'(tbl_used[s]); best = s; any = 1;
				end
			end
			if (!any) begin
				awaited.push_back(pack_answer(STAT_REJECT, 0, ev));
				return;
			end
			drop_slot(best);
			n_evict = n_evict + 1'b1;
			ev++;
		end
		if (tbl_key[slot] == 0) held_entries = held_entries + 1'b1;
		tbl_key[slot] = k;
		tbl_size[slot] = r.bytes;
		tbl_used[slot] = now_tick;
		held_bytes = held_bytes + BYTES_W'(r.bytes);
		n_upload = n_upload + 1'b1;
		awaited.push_back(pack_answer(STAT_INSERT, slot, ev));
	endtask

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h", field, got, want);
		errors++;
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) serve_request(cur);
			if (!start || !busy) begin
				if (pending.size() != 0 && !(pending[0].drain && awaited.size() != 0)
						&& $urandom_range(0, 99) >= send_idle_pct) begin
					cur = pending.pop_front();
					start <= 1'b1;
					layer_index <= cur.layer;
					weight_index <= cur.weight;
					byte_count <= cur.bytes;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		answer_t w;
		if (arst_n && done) begin
			if (awaited.size() == 0) begin
				report_mismatch("unexpected word", 64'(status), '0);
			end else begin
				w = awaited.pop_front();
				if (status !== w.stat)
					report_mismatch("status", 64'(status), 64'(w.stat));
				if (slot_index !== w.slot)
					report_mismatch("slot_index", 64'(slot_index), 64'(w.slot));
				if (evicted_now !== w.evicted)
					report_mismatch("evicted_now", 64'(evicted_now), 64'(w.evicted));
				if (hit_total !== w.hits)
					report_mismatch("hit_total", 64'(hit_total), 64'(w.hits));
				if (miss_total !== w.misses)
					report_mismatch("miss_total", 64'(miss_total), 64'(w.misses));
				if (eviction_total !== w.evictions)
					report_mismatch("eviction_total", 64'(eviction_total),
						64'(w.evictions));
				if (upload_total !== w.uploads)
					report_mismatch("upload_total", 64'(upload_total), 64'(w.uploads));
				if (bytes_in_use !== w.bytes)
					report_mismatch("bytes_in_use", 64'(bytes_in_use), 64'(w.bytes));
				if (entries_in_use !== w.entries)
					report_mismatch("entries_in_use", 64'(entries_in_use),
						64'(w.entries));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("lru_budget_hash_cache_tb NOT OK");
			$finish;
		end
	end

	task automatic add_req(int lay, int wt, logic [SIZE_W-1:0] sz, bit drn = 0);
		request_t r;
		r.layer = IDX_W'(lay);
		r.weight = IDX_W'(wt);
		r.bytes = sz;
		r.drain = drn;
		pending.push_back(r);
	endtask

	// settle after the edge, then return on a rising edge
	task automatic wait_idle();
		do @(negedge clk); while (pending.size() != 0 || start || awaited.size() != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTES_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_ENABLE) en_reg = val[0];
		else if (idx == CFG_BUDGET) budget_reg = val;
		@(posedge clk);
	endtask

	// mostly a small key pool with sticky sizes, some noise
	task automatic add_random(int count, int max_size);
		int lay, wt;
		logic [SIZE_W-1:0] sz;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 80) begin
				lay = $urandom_range(0, 7);
				wt = $urandom_range(0, 7);
				if ($urandom_range(0, 99) < 12) sz = $urandom_range(1, max_size);
				else sz = SIZE_W'(((lay * 8 + wt) % 5 + 1) * (max_size / 6));
				add_req(lay, wt, sz, i == count / 2);
			end else begin
				add_req($urandom, $urandom, $urandom);
			end
		end
	endtask

	initial begin
		for (int s = 0; s < SLOTS; s++) begin
			tbl_key[s] = '0; tbl_size[s] = '0; tbl_used[s] = '0;
		end
		now_tick = '0; held_bytes = '0; held_entries = '0;
		n_hit = '0; n_miss = '0; n_evict = '0; n_upload = '0;
		en_reg = 1'b0;
		budget_reg = BUDGET_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: disabled, size limits, hit, resize, eviction, key extremes
		send_idle_pct = 25;
		add_req(1, 1, 32'd100);
		wait_idle();
		write_reg(CFG_ENABLE, {40'hff_ffff_fffe, 1'b1});
		write_reg(CFG_SPARE, BYTES_W'($urandom));
		add_req(1, 1, 32'd0);
		add_req(1, 1, 32'd8388609);
		add_req(1, 1, 32'd8388608);
		add_req(1, 1, 32'd8388608);
		add_req(1, 1, 32'd4096);
		add_req(65535, 65535, 32'd1);
		add_req(0, 0, 32'd4194304);
		add_req(2, 3, 32'd4194304);
		add_req(65535, 65535, 32'd1);
		add_req(0, 0, 32'd4194304);
		add_req(0, 0, 32'hffff_ffff);
		wait_idle();

		// random at the smallest budget
		add_random(200, 4194304);
		wait_idle();

		// random at a mid budget, sender idles more
		send_idle_pct = 67;
		write_reg(CFG_BUDGET, 41'd33554432 + BYTES_W'($urandom_range(0, 1 << 20)));
		add_random(190, 16777216);
		wait_idle();

		// largest budget, full sizes, no idling
		send_idle_pct = 0;
		write_reg(CFG_BUDGET, 41'h100_0000_0000);
		write_reg(CFG_ENABLE, 41'd0);
		add_req(3, 3, 32'd7);
		wait_idle();
		write_reg(CFG_ENABLE, 41'd1);
		add_req(40000, 40000, 32'hffff_ffff);
		add_req(40000, 40000, 32'hffff_ffff);
		add_random(180, 32'h7fff_ffff);
		wait_idle();

		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("lru_budget_hash_cache_tb OK");
		end else begin
			$display("lru_budget_hash_cache_tb NOT OK");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/lbhc_pkg.sv
hw/rtl/lbhc_ram.sv
hw/rtl/lru_budget_hash_cache.sv
tb/sv/lru_budget_hash_cache_tb.sv
